>>> hdl/ffba_pkg.sv
// ffba_pkg: shared types, codes and sizes for the first-fit block allocator
// used by ffba_mod_unit, first_fit_block_allocator and ffba_checker, depends on nothing
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDR_W  = 64;
  localparam int SIZE_W  = 48;
  localparam int ALIGN_W = 17;

  localparam logic [1:0] MODE_ALIGNED = 2'd0;
  localparam logic [1:0] MODE_AT      = 2'd1;
  localparam logic [1:0] MODE_FREE    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_GAP    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] alignment;
    logic [ADDR_W-1:0]  address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
  } res_t;

endpackage

>>> hdl/ffba_ram.sv
// ffba_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ffba_mod_unit.sv
// ffba_mod_unit: bit-serial remainder of a 64-bit value by a 17-bit divisor
// one dividend bit per cycle; uses ffba_pkg
`timescale 1ns / 1ps
module ffba_mod_unit
  import ffba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [ADDR_W-1:0]  dividend,
  input  logic [ALIGN_W-1:0] divisor,
  output logic               done,
  output logic [ALIGN_W-1:0] rem
);

  logic [ADDR_W-1:0]  dvd;
  logic [ALIGN_W-1:0] dvs;
  logic [5:0]         cnt;
  logic               running;
  logic [ALIGN_W:0]   trial;
  logic [ALIGN_W-1:0] rem_next;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem, dvd[ADDR_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = ALIGN_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[ALIGN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        dvd     <= dividend;
        dvs     <= divisor;
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem <= rem_next;
        dvd <= {dvd[ADDR_W-2:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/first_fit_block_allocator.sv
// first_fit_block_allocator: address-ordered first-fit region allocator
// uses ffba_pkg, ffba_ram (base, size, link tables) and ffba_mod_unit
//
// channel   direction  handshake                  payload
// request   in         start & !busy              req (req_t)
// result    out        done, one cycle strobe     result (res_t)
// config    in         cfg_wen, always taken      cfg_wdata (heap_base)
//
// free: S_FRD, S_FLNK and S_FCMP per list entry walked, and S_FRD once at the list end
// allocate-at: S_RD, S_NXT, S_END, S_ADJ, S_DIFF, S_EVAL per entry walked; aligned adds
// S_MOD waiting on the serial remainder unit, then a free-entry scan of up to
// TABLE_ENTRIES entries and the S_INS, S_LNK insert states. synchronous reset leaves
// only the anchor in use; a heap_base write does the same. results cannot be stalled
`timescale 1ns / 1ps
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output res_t              result,
  input  logic              cfg_wen,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_NXT  = 4'd2;
  localparam logic [3:0] S_END  = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_ADJ  = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_EVAL = 4'd7;
  localparam logic [3:0] S_SCAN = 4'd8;
  localparam logic [3:0] S_INS  = 4'd9;
  localparam logic [3:0] S_LNK  = 4'd10;
  localparam logic [3:0] S_FRD  = 4'd11;
  localparam logic [3:0] S_FLNK = 4'd12;
  localparam logic [3:0] S_FCMP = 4'd13;

  logic [3:0] state;

  logic [ADDR_W-1:0]        heap_base;
  logic [TABLE_ENTRIES-1:0] in_use;
  logic [TABLE_ENTRIES-1:0] is_last;

  logic [1:0]         mode_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ALIGN_W-1:0] align_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [IDX_W-1:0]   cur;
  logic [IDX_W-1:0]   cf;
  logic [IDX_W-1:0]   link_r;
  logic [IDX_W-1:0]   steps;
  logic [IDX_W-1:0]   fresh;
  logic [ADDR_W-1:0]  start_r;
  logic [ADDR_W-1:0]  end_r;
  logic [ADDR_W-1:0]  at_r;
  logic [ADDR_W-1:0]  diff_r;
  logic               skip_r;
  logic               in_gap_r;
  logic               gt_r;
  logic               above_r;

  logic [IDX_W-1:0]   raddr;
  logic [ADDR_W-1:0]  base_q;
  logic [SIZE_W-1:0]  size_q;
  logic [IDX_W-1:0]   link_q;
  logic               tab_we;
  logic               link_we;
  logic [IDX_W-1:0]   link_waddr;
  logic [IDX_W-1:0]   link_wdata;

  logic               mod_go;
  logic               mod_done;
  logic [ALIGN_W-1:0] mod_rem;
  logic [ALIGN_W-1:0] add_amt;
  logic [ADDR_W:0]    rounded;

  assign busy = (state != S_IDLE);

  assign raddr  = (state == S_NXT || state == S_FLNK) ? link_q : cur;
  assign tab_we = (state == S_INS);
  assign mod_go = (state == S_END) && (mode_r == MODE_ALIGNED);

  always_comb begin
    link_we    = 1'b0;
    link_waddr = fresh;
    link_wdata = link_r;
    unique case (state)
      S_INS: begin
        link_we    = 1'b1;
        link_waddr = fresh;
        link_wdata = is_last[cur] ? '0 : link_r;
      end
      S_LNK: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = fresh;
      end
      S_FCMP: begin
        link_we    = (addr_r == base_q) && !is_last[cf];
        link_waddr = cur;
        link_wdata = link_q;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  ffba_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_base_ram (
    .clk(clk), .we(tab_we), .waddr(fresh), .wdata(at_r), .raddr(raddr), .rdata(base_q)
  );

  ffba_ram #(.WIDTH(SIZE_W), .DEPTH(TABLE_ENTRIES)) u_size_ram (
    .clk(clk), .we(tab_we), .waddr(fresh), .wdata(size_r), .raddr(raddr), .rdata(size_q)
  );

  ffba_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(raddr), .rdata(link_q)
  );

  ffba_mod_unit u_mod (
    .clk(clk), .rst(rst), .go(mod_go), .dividend(start_r), .divisor(align_r),
    .done(mod_done), .rem(mod_rem)
  );

  // round the gap start up to the alignment; carry out means it wrapped
  assign add_amt = align_r - mod_rem;
  assign rounded = {1'b0, start_r} + {{(ADDR_W + 1 - ALIGN_W){1'b0}}, add_amt};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      heap_base <= '0;
      in_use    <= {{(TABLE_ENTRIES - 1){1'b0}}, 1'b1};
      is_last   <= {{(TABLE_ENTRIES - 1){1'b0}}, 1'b1};
    end else begin
      done <= 1'b0;
      if (cfg_wen) begin
        heap_base <= cfg_wdata;
        in_use    <= {{(TABLE_ENTRIES - 1){1'b0}}, 1'b1};
        is_last   <= {{(TABLE_ENTRIES - 1){1'b0}}, 1'b1};
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode_r  <= req.mode;
            size_r  <= req.request_size;
            align_r <= (req.alignment == '0) ? ALIGN_W'(1) : req.alignment;
            addr_r  <= req.address;
            cur     <= '0;
            steps   <= '0;
            unique case (req.mode)
              MODE_ALIGNED, MODE_AT: state <= S_RD;
              MODE_FREE:             state <= S_FRD;
              default: begin
                result <= '{result_address: '0, status: ST_NO_GAP};
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_RD: state <= S_NXT;
        S_NXT: begin
          // the anchor's base follows heap_base and its size is zero
          if (cur == '0) begin
            start_r <= heap_base;
          end else begin
            start_r <= base_q + {{(ADDR_W - SIZE_W){1'b0}}, size_q};
          end
          link_r <= link_q;
          state  <= S_END;
        end
        S_END: begin
          end_r <= is_last[cur] ? '1 : base_q;
          state <= (mode_r == MODE_ALIGNED) ? S_MOD : S_ADJ;
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          if (mode_r == MODE_ALIGNED) begin
            skip_r <= (mod_rem != '0) && rounded[ADDR_W];
            at_r   <= (mod_rem == '0) ? start_r : rounded[ADDR_W-1:0];
          end else begin
            in_gap_r <= (addr_r >= start_r) && (addr_r < end_r);
            at_r     <= addr_r;
          end
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff_r  <= end_r - at_r;
          gt_r    <= end_r > at_r;
          above_r <= at_r > heap_base;
          state   <= S_EVAL;
        end
        S_EVAL: begin
          priority if (mode_r == MODE_ALIGNED && !skip_r && gt_r && above_r &&
                       diff_r > {{(ADDR_W - SIZE_W){1'b0}}, size_r}) begin
            fresh <= '0;
            state <= S_SCAN;
          end else if (mode_r == MODE_AT && in_gap_r) begin
            if (diff_r > {{(ADDR_W - SIZE_W){1'b0}}, size_r}) begin
              fresh <= '0;
              state <= S_SCAN;
            end else begin
              result <= '{result_address: '0, status: ST_NO_GAP};
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end else if (is_last[cur] || steps == LAST_IDX) begin
            result <= '{result_address: '0, status: ST_NO_GAP};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            cur   <= link_r;
            steps <= steps + 1'b1;
            state <= S_RD;
          end
        end
        S_SCAN: begin
          if (!in_use[fresh]) begin
            state <= S_INS;
          end else if (fresh == LAST_IDX) begin
            result <= '{result_address: '0, status: ST_FULL};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            fresh <= fresh + 1'b1;
          end
        end
        S_INS: begin
          in_use[fresh] <= 1'b1;
          if (is_last[cur]) begin
            is_last[fresh] <= 1'b1;
            is_last[cur]   <= 1'b0;
          end else begin
            is_last[fresh] <= 1'b0;
          end
          state <= S_LNK;
        end
        S_LNK: begin
          result <= '{result_address: at_r, status: ST_OK};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_FRD: begin
          if (is_last[cur]) begin
            result <= '{result_address: '0, status: ST_NOT_FOUND};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_FLNK;
          end
        end
        S_FLNK: begin
          cf    <= link_q;
          state <= S_FCMP;
        end
        S_FCMP: begin
          // cur is the predecessor, cf the candidate region
          if (addr_r == base_q) begin
            if (is_last[cf]) begin
              is_last[cur] <= 1'b1;
            end
            in_use[cf]  <= 1'b0;
            is_last[cf] <= 1'b0;
            result <= '{result_address: '0, status: ST_OK};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (steps == LAST_IDX) begin
            result <= '{result_address: '0, status: ST_NOT_FOUND};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            cur   <= cf;
            steps <= steps + 1'b1;
            state <= S_FRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/ffba_checker.sv
// ffba_checker: port-level assertions for the allocator, bound to the top level
// uses ffba_pkg
`timescale 1ns / 1ps
module ffba_checker
  import ffba_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);

  // a request only ends with a result
  a_busy_ends_with_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> busy || done)
    else $error("busy dropped without a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.result_address == '0)
    else $error("failed request returned an address");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done)
    else $error("result without a request");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("activity right after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
